// File: design/fud_pkg.sv
`default_nettype none

package fud_pkg;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // escape phase codes
  localparam logic [1:0] PH_NONE = 2'd0;
  localparam logic [1:0] PH_PCT  = 2'd1;
  localparam logic [1:0] PH_HEX1 = 2'd2;

  localparam int MAX_RES  = 4;
  localparam int Q_DEPTH  = 8;
  localparam int Q_AW     = $clog2(Q_DEPTH);
  localparam int RES_CW   = $clog2(MAX_RES + 1);

  typedef struct packed {
    logic       run_last;
    logic       had_equals;
    logic       pair_end;
    logic       is_value;
    logic       byte_valid;
    logic [7:0] out_byte;
  } res_t;

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
             (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_nib(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) begin
      hex_nib = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      hex_nib = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      hex_nib = 4'(c - 8'h37);
    end else begin
      hex_nib = 4'd0;
    end
  endfunction

endpackage

`default_nettype wire

// File: design/form_urlencoded_decoder_top.sv
// Results are registered in the 8-entry result queue and leave it in order on the out_ side.
// Throughput: one request per cycle while in_tready is high; one result per cycle leaves
// the queue while out_tready is high. As a byte can cause up to 4 results (escape flushes,
// pair ends), in_tready is low below four free slots, so the output port sets the rate.
// Reset: rst_n synchronous, active low; clears decoder state and empties the queue.
`default_nettype none

module form_urlencoded_decoder_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] in_byte
  input  wire logic       in_tlast,   // end_of_body
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_byte
  output logic [3:0]      out_tuser,  // [0] byte_valid [1] is_value [2] pair_end [3] had_equals
  output logic            out_tlast   // run_last
);
  import fud_pkg::*;

  // decoder state
  logic [1:0] ph_r, ph_nxt;
  logic [7:0] held_r, held_nxt;
  logic       inv_r, inv_nxt;   // in value part
  logic       seg_r, seg_nxt;   // segment has seen a raw byte

  // results generated by the byte at the input this cycle
  res_t              gen_res [MAX_RES];
  logic [RES_CW-1:0] gen_n;
  logic [RES_CW-1:0] last_idx;

  // result queue
  res_t            q_r [Q_DEPTH];
  logic [Q_AW-1:0] wptr_r, rptr_r;
  logic [Q_AW:0]   cnt_r, cnt_nxt;

  logic in_acc, out_acc;
  logic do_plain, do_flush;

  assign in_tready = (cnt_r <= (Q_AW+1)'(Q_DEPTH - MAX_RES));
  assign in_acc    = in_tvalid && in_tready;
  assign out_tvalid = (cnt_r != '0);
  assign out_acc   = out_tvalid && out_tready;

  assign out_tdata = q_r[rptr_r].out_byte;
  assign out_tuser = {q_r[rptr_r].had_equals, q_r[rptr_r].pair_end,
                      q_r[rptr_r].is_value, q_r[rptr_r].byte_valid};
  assign out_tlast = q_r[rptr_r].run_last;

  // Single pass over one byte: escape handling, then plain handling, then the
  // end-of-body flush and close. Results are appended in order to gen_res.
  always_comb begin
    ph_nxt   = ph_r;
    held_nxt = held_r;
    inv_nxt  = inv_r;
    seg_nxt  = seg_r;
    gen_n    = '0;
    last_idx = '0;
    do_plain = 1'b0;
    do_flush = 1'b0;
    for (int k = 0; k < MAX_RES; k++) begin
      gen_res[k] = '0;
    end

    if (ph_r == PH_PCT && is_hex(in_tdata)) begin
      held_nxt = in_tdata;
      ph_nxt   = PH_HEX1;
    end else if (ph_r == PH_HEX1 && is_hex(in_tdata)) begin
      gen_res[gen_n[1:0]] = '{run_last: 1'b0, had_equals: 1'b0, pair_end: 1'b0,
                              is_value: inv_nxt, byte_valid: 1'b1,
                              out_byte: {hex_nib(held_r), hex_nib(in_tdata)}};
      gen_n    = gen_n + 1'b1;
      ph_nxt   = PH_NONE;
      held_nxt = '0;
    end else begin
      do_flush = 1'b1;
      do_plain = 1'b1;
    end

    // flush a pending escape literally (phase code 3 counts as none)
    if (do_flush) begin
      if (ph_r == PH_PCT || ph_r == PH_HEX1) begin
        gen_res[gen_n[1:0]] = '{run_last: 1'b0, had_equals: 1'b0, pair_end: 1'b0,
                                is_value: inv_nxt, byte_valid: 1'b1, out_byte: CH_PCT};
        gen_n = gen_n + 1'b1;
      end
      if (ph_r == PH_HEX1) begin
        gen_res[gen_n[1:0]] = '{run_last: 1'b0, had_equals: 1'b0, pair_end: 1'b0,
                                is_value: inv_nxt, byte_valid: 1'b1, out_byte: held_r};
        gen_n = gen_n + 1'b1;
      end
      ph_nxt   = PH_NONE;
      held_nxt = '0;
    end

    if (do_plain) begin
      if (in_tdata == CH_AMP) begin
        if (seg_nxt) begin
          gen_res[gen_n[1:0]] = '{run_last: 1'b0, had_equals: inv_nxt, pair_end: 1'b1,
                                  is_value: 1'b0, byte_valid: 1'b0, out_byte: 8'h00};
          gen_n = gen_n + 1'b1;
        end
        seg_nxt = 1'b0;
        inv_nxt = 1'b0;
      end else begin
        seg_nxt = 1'b1;
        if (in_tdata == CH_EQ && !inv_nxt) begin
          inv_nxt = 1'b1;
        end else if (in_tdata == CH_PCT) begin
          ph_nxt = PH_PCT;
        end else begin
          gen_res[gen_n[1:0]] = '{run_last: 1'b0, had_equals: 1'b0, pair_end: 1'b0,
                                  is_value: inv_nxt, byte_valid: 1'b1,
                                  out_byte: (in_tdata == CH_PLUS) ? CH_SPACE : in_tdata};
          gen_n = gen_n + 1'b1;
        end
      end
    end

    // end of body: flush, close the pair, back to reset state
    if (in_tlast) begin
      if (ph_nxt == PH_PCT || ph_nxt == PH_HEX1) begin
        gen_res[gen_n[1:0]] = '{run_last: 1'b0, had_equals: 1'b0, pair_end: 1'b0,
                                is_value: inv_nxt, byte_valid: 1'b1, out_byte: CH_PCT};
        gen_n = gen_n + 1'b1;
      end
      if (ph_nxt == PH_HEX1) begin
        gen_res[gen_n[1:0]] = '{run_last: 1'b0, had_equals: 1'b0, pair_end: 1'b0,
                                is_value: inv_nxt, byte_valid: 1'b1, out_byte: held_nxt};
        gen_n = gen_n + 1'b1;
      end
      if (seg_nxt) begin
        gen_res[gen_n[1:0]] = '{run_last: 1'b0, had_equals: inv_nxt, pair_end: 1'b1,
                                is_value: 1'b0, byte_valid: 1'b0, out_byte: 8'h00};
        gen_n = gen_n + 1'b1;
      end
      ph_nxt   = PH_NONE;
      held_nxt = '0;
      inv_nxt  = 1'b0;
      seg_nxt  = 1'b0;
    end

    if (gen_n != '0) begin
      last_idx = gen_n - 1'b1;
      gen_res[last_idx[1:0]].run_last = 1'b1;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_acc) begin
      cnt_nxt = cnt_nxt + (Q_AW+1)'(gen_n);
    end
    if (out_acc) begin
      cnt_nxt = cnt_nxt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_NONE;
      held_r <= '0;
      inv_r  <= 1'b0;
      seg_r  <= 1'b0;
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (in_acc) begin
        ph_r   <= ph_nxt;
        held_r <= held_nxt;
        inv_r  <= inv_nxt;
        seg_r  <= seg_nxt;
        wptr_r <= wptr_r + Q_AW'(gen_n);
      end
      if (out_acc) begin
        rptr_r <= rptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  // queue payload, no reset
  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_RES; k++) begin
      if (in_acc && (RES_CW'(k) < gen_n)) begin
        q_r[wptr_r + Q_AW'(k)] <= gen_res[k];
      end
    end
  end

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (Q_AW+1)'(Q_DEPTH))
    else $error("result queue overflow");

  a_body_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tlast |=> ph_r == PH_NONE && !inv_r && !seg_r && held_r == '0)
    else $error("state not cleared after end of body");

  a_pair_end_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[2]))
    else $error("result marked both byte and pair end");

  a_results_marked_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && gen_n != '0 |-> gen_res[last_idx[1:0]].run_last)
    else $error("last result of a request not marked");

endmodule

`default_nettype wire

// File: test/form_urlencoded_decoder_top_test.sv
`default_nettype none

module form_urlencoded_decoder_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fud_pkg::*;

  // Run sizing
  localparam int RAND_ITEMS  = 380;      // random bytes to push through
  localparam int HOLD_CYCLES = 80;       // long output hold-off
  localparam int DRAIN_CYCLES = 8;       // settle time after the last result
  localparam int CYCLE_LIMIT = 300000;   // watchdog limit
  localparam int PRINT_CAP   = 100;      // mismatch lines printed before going quiet

  // Decoder state mirror plus the queue of results still owed by the block.
  class decode_scoreboard;
    logic [1:0] esc_phase;
    logic [7:0] held_digit;
    bit         in_value;
    bit         seg_open;
    res_t       owed_q[$];
    res_t       step_res[$];
    int         errors;
    int         checked;
    int         pair_ends;
    int         requests;

    function new();
      reset_state();
      errors    = 0;
      checked   = 0;
      pair_ends = 0;
      requests  = 0;
    endfunction

    function void reset_state();
      esc_phase  = PH_NONE;
      held_digit = 8'h00;
      in_value   = 1'b0;
      seg_open   = 1'b0;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function bit is_hex_digit(logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function logic [3:0] nibble_of(logic [7:0] c);
      logic [7:0] v;
      if (c >= "0" && c <= "9") begin
        v = c - "0";
      end else if (c >= "a" && c <= "f") begin
        v = c - "a" + 8'd10;
      end else begin
        v = c - "A" + 8'd10;
      end
      return v[3:0];
    endfunction

    function void emit(logic [7:0] b, bit valid, bit isv, bit pe, bit he);
      res_t r;
      if (step_res.size() >= MAX_RES) return;
      r.out_byte   = b;
      r.byte_valid = valid;
      r.is_value   = isv;
      r.pair_end   = pe;
      r.had_equals = he;
      r.run_last   = 1'b0;
      step_res.insert(step_res.size(), r);
    endfunction

    function void emit_byte(logic [7:0] b);
      emit(b, 1'b1, in_value, 1'b0, 1'b0);
    endfunction

    function void close_pair();
      if (seg_open) emit(8'h00, 1'b0, 1'b0, 1'b1, in_value);
      seg_open = 1'b0;
      in_value = 1'b0;
    endfunction

    // byte with no escape open
    function void handle_plain(logic [7:0] c);
      if (c == CH_AMP) begin
        close_pair();
        return;
      end
      seg_open = 1'b1;
      if (c == CH_EQ && !in_value) begin
        in_value = 1'b1;
      end else if (c == CH_PCT) begin
        esc_phase = PH_PCT;
      end else if (c == CH_PLUS) begin
        emit_byte(CH_SPACE);
      end else begin
        emit_byte(c);
      end
    endfunction

    // open escape goes out literally
    function void flush_escape();
      if (esc_phase == PH_PCT) begin
        emit_byte(CH_PCT);
      end else if (esc_phase == PH_HEX1) begin
        emit_byte(CH_PCT);
        emit_byte(held_digit);
      end
      esc_phase  = PH_NONE;
      held_digit = 8'h00;
    endfunction

    // Accepted input request: work out what it owes.
    function void note_request(logic [7:0] c, bit last);
      step_res.delete();
      requests++;
      if (esc_phase == PH_PCT) begin
        if (is_hex_digit(c)) begin
          held_digit = c;
          esc_phase  = PH_HEX1;
        end else begin
          flush_escape();
          handle_plain(c);
        end
      end else if (esc_phase == PH_HEX1) begin
        if (is_hex_digit(c)) begin
          emit_byte({nibble_of(held_digit), nibble_of(c)});
          esc_phase  = PH_NONE;
          held_digit = 8'h00;
        end else begin
          flush_escape();
          handle_plain(c);
        end
      end else begin
        esc_phase = PH_NONE;
        handle_plain(c);
      end
      if (last) begin
        flush_escape();
        close_pair();
        reset_state();
      end
      if (step_res.size() > 0) step_res[step_res.size() - 1].run_last = 1'b1;
      foreach (step_res[i]) owed_q.insert(owed_q.size(), step_res[i]);
    endfunction

    task report(string what);
      if (errors < PRINT_CAP) $display("MISMATCH at result %0d: %s", checked, what);
      errors++;
    endtask

    task match_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want) report($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    // Accepted result: compare against the oldest owed one.
    task check_result(logic [7:0] data, logic [3:0] user, logic last);
      res_t want;
      if (owed_q.size() == 0) begin
        report($sformatf("unexpected result data 0x%0h user 0x%0h", data, user));
        return;
      end
      want = owed_q.pop_front();
      checked++;
      if (want.pair_end) pair_ends++;
      match_field("out_byte", data, want.out_byte);
      match_field("byte_valid", 8'(user[0]), 8'(want.byte_valid));
      match_field("is_value", 8'(user[1]), 8'(want.is_value));
      match_field("pair_end", 8'(user[2]), 8'(want.pair_end));
      match_field("had_equals", 8'(user[3]), 8'(want.had_equals));
      match_field("run_last", 8'(last), 8'(want.run_last));
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;
  logic       in_tlast;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;
  logic [3:0] out_tuser;
  logic       out_tlast;

  decode_scoreboard sb;

  logic [7:0] body_q[$];       // raw bytes of the body being sent
  bit         tx_steady;       // sender offers back to back
  bit         rx_steady;       // receiver never stalls
  bit         hold_off_req;    // main asks receiver for one long hold
  int         cycle_count = 0;
  int         bodies_sent = 0;

  form_urlencoded_decoder_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #4 clk = ~clk;

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still owed", cycle_count, sb.pending());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result monitor; values seen here are the ones from before the edge.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser, out_tlast);
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  // Receiver: random stalls, plus the one long hold that lets the result
  // queue fill and push back on in_tready.
  initial begin
    int n;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        n = rx_steady ? 0 : pick_gap();
        if (n > 0) begin
          out_tready <= 1'b0;
          repeat (n) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      @(posedge clk);
    end
  end

  // One input request; valid stays up between back-to-back bytes.
  task automatic send_item(input logic [7:0] b, input logic last);
    int gap;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    sb.note_request(b, last);
  endtask

  task automatic send_body();
    foreach (body_q[i]) send_item(body_q[i], i == body_q.size() - 1);
    bodies_sent++;
  endtask

  // Sender goes quiet until every owed result is out.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic void add_byte(logic [7:0] b);
    body_q.insert(body_q.size(), b);
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic logic [7:0] pick_char(string set);
    return set[$urandom_range(0, set.len() - 1)];
  endfunction

  // One piece of key or value text.
  function automatic void add_token();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      add_byte(pick_char(
          "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789"));
    end else if (r < 60) begin
      add_byte(CH_PLUS);
    end else if (r < 78) begin
      // good escape, mixed-case digits
      add_byte(CH_PCT);
      add_byte(pick_char("0123456789abcdefABCDEF"));
      add_byte(pick_char("0123456789abcdefABCDEF"));
    end else if (r < 88) begin
      // bad or cut-short escape; a cut one stays open into the next byte or the end of the body
      add_byte(CH_PCT);
      if ($urandom_range(0, 1)) add_byte(pick_char("0123456789abcdefABCDEF"));
      if ($urandom_range(0, 1)) add_byte(pick_char("ghxyzGZ %+"));
    end else if (r < 93) begin
      add_byte(CH_EQ);
    end else begin
      add_byte(8'($urandom_range(0, 255)));
    end
  endfunction

  // key=value&key=value..., sometimes no '=', stray or doubled '&'
  function automatic void build_form();
    int npairs;
    int nk;
    int nv;
    npairs = $urandom_range(1, 4);
    for (int p = 0; p < npairs; p++) begin
      nk = $urandom_range(0, 4);
      repeat (nk) add_token();
      if ($urandom_range(0, 99) < 80) begin
        add_byte(CH_EQ);
        nv = $urandom_range(0, 5);
        repeat (nv) add_token();
      end
      if (p != npairs - 1 || $urandom_range(0, 99) < 15) add_byte(CH_AMP);
      if ($urandom_range(0, 99) < 10) add_byte(CH_AMP);
    end
    if (body_q.size() == 0) add_token();
  endfunction

  // short junk: any byte, leaning on the delimiters
  function automatic void build_noise();
    int len;
    len = $urandom_range(1, 8);
    repeat (len) begin
      if ($urandom_range(0, 99) < 60) begin
        add_byte(8'($urandom_range(0, 255)));
      end else begin
        add_byte(pick_char("%&=+aF9"));
      end
    end
  endfunction

  initial begin
    int rand_items;
    int body_idx;
    sb           = new();
    rst_n        <= 1'b0;
    in_tvalid    <= 1'b0;
    in_tdata     <= 8'h00;
    in_tlast     <= 1'b0;
    tx_steady    = 1'b0;
    rx_steady    = 1'b0;
    hold_off_req = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed bodies.
    // Lower/upper escapes, '+', escape right before '&', empty segment,
    // pair with empty key.
    body_q.delete();
    add_text("%4a+=%7E&&=x");
    send_body();
    // '%' then '%', escape open at '=', pair closed by '&'
    body_q.delete();
    add_text("%%4=&");
    send_body();
    // digit then non-hex, later '=' is value data, bare '%' at the end
    body_q.delete();
    add_text("a%4g==%");
    send_body();
    // byte extremes, then an escape decoded on the last byte
    body_q.delete();
    add_byte(8'h00);
    add_byte(8'hFF);
    add_text("%41");
    send_body();

    // Random bodies; most are key=value forms with random content.
    rand_items = 0;
    body_idx   = 0;
    while (rand_items < RAND_ITEMS) begin
      body_q.delete();
      if ($urandom_range(0, 99) < 85) begin
        build_form();
      end else begin
        build_noise();
      end
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      // long output hold while the sender keeps pushing back to back
      if (body_idx == 8) begin
        hold_off_req = 1'b1;
        rx_steady    = 1'b0;
      end
      if (body_idx >= 8 && body_idx < 11) tx_steady = 1'b1;
      // sender pause until the block has emptied out
      if (body_idx == 30) wait_drained();
      send_body();
      rand_items += body_q.size();
      body_idx++;
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d bodies / %0d byte requests: escapes good, bad and cut short,",
             bodies_sent, sb.requests);
    $display("delimiters, byte extremes and noise; %0d results checked, %0d pair ends.",
             sb.checked, sb.pair_ends);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
design/fud_pkg.sv
design/form_urlencoded_decoder_top.sv
test/form_urlencoded_decoder_top_test.sv
